@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/slfw_pkg.sv @@
`default_nettype none

package slfw_pkg;

    // Request codes.
    localparam logic [1:0] REQ_CMD    = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_NUMBER = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // Frame ID bits and lengths.
    localparam logic [2:0] CMD_ID    = 3'b100;
    localparam logic [2:0] WRITE_ID  = 3'b101;
    localparam logic [3:0] CMD_LEN   = 4'd11;
    localparam logic [3:0] WRITE_LEN = 4'd13;

    // Reciprocal constants for division by ten.
    // (x * 0xCCCD) >> 19 is exact for 16-bit x; (x * 205) >> 11 for x below 1029.
    localparam logic [15:0] DIV10_MUL_WIDE  = 16'hCCCD;
    localparam logic [7:0]  DIV10_MUL_SMALL = 8'd205;

    // Queue between the front and the back.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] command_byte;
        logic [5:0] ram_address;
        logic [3:0] nibble_value;
        logic [3:0] digit_ones;
        logic [3:0] digit_tens;
        logic [3:0] digit_hundreds;
        logic       show_tens;
        logic       show_hundreds;
    } slfw_item_t;

    // First nibble of a digit's segment pattern (lower address).
    function automatic logic [3:0] seg_first(input logic [3:0] d);
        logic [3:0] r;
        case (d)
            4'd0:    r = 4'hB;
            4'd1:    r = 4'h0;
            4'd2:    r = 4'h7;
            4'd3:    r = 4'h5;
            4'd4:    r = 4'hC;
            4'd5:    r = 4'hD;
            4'd6:    r = 4'hF;
            4'd7:    r = 4'h8;
            4'd8:    r = 4'hF;
            4'd9:    r = 4'hD;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    // Second nibble of a digit's segment pattern (upper address).
    function automatic logic [3:0] seg_second(input logic [3:0] d);
        logic [3:0] r;
        case (d)
            4'd0:    r = 4'hE;
            4'd1:    r = 4'h6;
            4'd2:    r = 4'hC;
            4'd3:    r = 4'hE;
            4'd4:    r = 4'h6;
            4'd5:    r = 4'hA;
            4'd6:    r = 4'hA;
            4'd7:    r = 4'hE;
            4'd8:    r = 4'hE;
            4'd9:    r = 4'hE;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    // Data nibbles go out LSB first, so they sit bit-reversed in the frame.
    function automatic logic [3:0] reverse4(input logic [3:0] v);
        return {v[0], v[1], v[2], v[3]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/segment_lcd_frame_writer_unit.sv @@
//  Channel   Direction  Handshake          Carries
//  s_        in         s_valid/s_ready    one request (type, command, address, nibble, number)
//  m_        out        m_valid/m_ready    one serial frame (word, length, last marker)
//
//  Command and nibble requests give one frame; a number request gives 8, 10 or 12.
//  Frames leave at one per cycle while m_ready is high and requests are waiting;
//  the back sequencer, which emits them from its output register, sets this.
//  On an empty path the first frame passes front stage 1, front stage 2, the queue
//  and the output register before it reaches the output.
//  Reset (aresetn low at a clock edge) empties the pipeline, queue and output register.
//  Either side may stall: a four-entry queue decouples request intake from output.
`default_nettype none

`include "assert_macros.svh"

module segment_lcd_frame_writer_unit
    import slfw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [7:0]  s_command_byte,
    input  wire logic [5:0]  s_ram_address,
    input  wire logic [3:0]  s_nibble_value,
    input  wire logic [15:0] s_number_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [12:0]      m_frame_word,
    output logic [3:0]       m_frame_length,
    output logic             m_last_frame
);

    // Front to queue.
    logic       fq_valid;
    logic       fq_ready;
    slfw_item_t fq_item;

    // Queue to back.
    logic       qb_valid;
    logic       qb_ready;
    slfw_item_t qb_item;

    // The front takes one request per cycle while the queue has room, splits the number into
    // decimal digits with two reciprocal multiplier stages, and drops unused codes.
    slfw_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_command_byte (s_command_byte),
        .s_ram_address  (s_ram_address),
        .s_nibble_value (s_nibble_value),
        .s_number_value (s_number_value),
        .out_valid      (fq_valid),
        .out_ready      (fq_ready),
        .out_item       (fq_item)
    );

    // Short queue of classified requests, so intake keeps going while
    // a long number request is still being written out.
    slfw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // The back sequences each request into frames and holds the current
    // frame in an output register until it is transferred.
    slfw_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (qb_valid),
        .in_ready       (qb_ready),
        .in_item        (qb_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_word   (m_frame_word),
        .m_frame_length (m_frame_length),
        .m_last_frame   (m_last_frame)
    );

    // A command frame is always the only frame of its request.
    `ASSERT_IMPLIES(a_cmd_is_last, aclk, aresetn, m_valid && (m_frame_length == CMD_LEN), m_last_frame)

    // Every frame that is not a command frame is a 13-bit write frame.
    `ASSERT_IMPLIES(a_write_shape, aclk, aresetn, m_valid && (m_frame_length != CMD_LEN), (m_frame_length == WRITE_LEN) && (m_frame_word[12:10] == WRITE_ID))

    // Command frames carry their ID with zeros above the frame length.
    `ASSERT_IMPLIES(a_cmd_shape, aclk, aresetn, m_valid && (m_frame_length == CMD_LEN), m_frame_word[12:8] == {2'b00, CMD_ID})

    // The queue never sees a push it cannot hold being dropped by the front.
    `ASSERT_NEXT(a_front_holds, aclk, aresetn, fq_valid && !fq_ready, fq_valid && $stable(fq_item))

endmodule

`default_nettype wire

@@ rtl/slfw_front.sv @@
`default_nettype none

module slfw_front
    import slfw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [7:0]  s_command_byte,
    input  wire logic [5:0]  s_ram_address,
    input  wire logic [3:0]  s_nibble_value,
    input  wire logic [15:0] s_number_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output slfw_item_t       out_item
);

    // Stage 1: request captured with the value divided by ten.
    logic        v1_reg;
    logic [1:0]  req1_reg;
    logic [7:0]  cmd1_reg;
    logic [5:0]  addr1_reg;
    logic [3:0]  nib1_reg;
    logic [15:0] n1_reg;
    logic [12:0] q1_reg;

    // Stage 2: ones digit known, value divided by one hundred.
    logic        v2_reg;
    logic [1:0]  req2_reg;
    logic [7:0]  cmd2_reg;
    logic [5:0]  addr2_reg;
    logic [3:0]  nib2_reg;
    logic [3:0]  d0_2_reg;
    logic [12:0] q1_2_reg;
    logic [9:0]  q2_2_reg;
    logic        show1_2_reg;
    logic        show2_2_reg;

    logic [31:0] prod1;
    logic [28:0] prod2;
    logic [17:0] prod3;
    logic [9:0]  q2;
    logic [6:0]  q3;
    logic [16:0] ten_q1;
    logic [13:0] ten_q2;
    logic [10:0] ten_q3;
    logic [3:0]  d0;
    logic        drop2;
    logic        adv2;

    assign prod1  = 32'(s_number_value) * 32'(DIV10_MUL_WIDE);
    assign prod2  = 29'(q1_reg) * 29'(DIV10_MUL_WIDE);
    assign q2     = prod2[28:19];
    assign ten_q1 = {1'b0, q1_reg, 3'b000} + {3'b000, q1_reg, 1'b0};
    assign d0     = n1_reg[3:0] - ten_q1[3:0];

    assign prod3  = 18'(q2_2_reg) * 18'(DIV10_MUL_SMALL);
    assign q3     = prod3[17:11];
    assign ten_q2 = {1'b0, q2_2_reg, 3'b000} + {3'b000, q2_2_reg, 1'b0};
    assign ten_q3 = {1'b0, q3, 3'b000} + {3'b000, q3, 1'b0};

    // Unused request codes are dropped here and never reach the queue.
    assign drop2     = v2_reg && (req2_reg == REQ_NONE);
    assign out_valid = v2_reg && !drop2;
    assign adv2      = !v2_reg || drop2 || out_ready;
    assign s_ready   = !v1_reg || adv2;

    always_comb begin
        out_item.req_type       = req2_reg;
        out_item.command_byte   = cmd2_reg;
        out_item.ram_address    = addr2_reg;
        out_item.nibble_value   = nib2_reg;
        out_item.digit_ones     = d0_2_reg;
        out_item.digit_tens     = q1_2_reg[3:0] - ten_q2[3:0];
        out_item.digit_hundreds = q2_2_reg[3:0] - ten_q3[3:0];
        out_item.show_tens      = show1_2_reg;
        out_item.show_hundreds  = show2_2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            req1_reg  <= s_req_type;
            cmd1_reg  <= s_command_byte;
            addr1_reg <= s_ram_address;
            nib1_reg  <= s_nibble_value;
            n1_reg    <= s_number_value;
            q1_reg    <= prod1[31:19];
        end
        if (adv2) begin
            req2_reg    <= req1_reg;
            cmd2_reg    <= cmd1_reg;
            addr2_reg   <= addr1_reg;
            nib2_reg    <= nib1_reg;
            d0_2_reg    <= d0;
            q1_2_reg    <= q1_reg;
            q2_2_reg    <= q2;
            show1_2_reg <= (q1_reg != 13'd0);
            show2_2_reg <= (q2 != 10'd0);
        end
    end

endmodule

`default_nettype wire

@@ rtl/slfw_queue.sv @@
`default_nettype none

module slfw_queue
    import slfw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  wire slfw_item_t  push_item,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output slfw_item_t       pop_item
);

    slfw_item_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/slfw_back.sv @@
`default_nettype none

module slfw_back
    import slfw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire slfw_item_t  in_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [12:0]      m_frame_word,
    output logic [3:0]       m_frame_length,
    output logic             m_last_frame
);

    logic        busy_reg;
    logic        busy_next;
    slfw_item_t  ent_reg;
    slfw_item_t  ent_next;
    logic [3:0]  step_reg;
    logic [3:0]  step_next;

    logic        m_valid_reg;
    logic        m_valid_next;
    logic [12:0] m_word_reg;
    logic [3:0]  m_len_reg;
    logic        m_last_reg;

    slfw_item_t  cur;
    logic [3:0]  step;
    logic        load;
    logic        emit;

    logic [1:0]  dig;
    logic [1:0]  sub;
    logic [3:0]  dval;
    logic        shown;
    logic        digit_done;
    logic [2:0]  base;
    logic [5:0]  waddr;
    logic [3:0]  wnib;
    logic [12:0] f_word;
    logic [3:0]  f_len;
    logic        f_last;
    logic [3:0]  f_next;

    assign cur      = busy_reg ? ent_reg : in_item;
    assign step     = busy_reg ? step_reg : 4'd0;
    assign load     = !m_valid_reg || m_ready;
    assign emit     = (busy_reg || in_valid) && load;
    assign in_ready = !busy_reg && load;

    assign m_valid        = m_valid_reg;
    assign m_frame_word   = m_word_reg;
    assign m_frame_length = m_len_reg;
    assign m_last_frame   = m_last_reg;

    // Number requests walk ones, tens, hundreds; each digit is two clears
    // and, when shown, its two segment nibbles.
    always_comb begin
        dig  = step[3:2];
        sub  = step[1:0];
        base = 3'd4 - {dig, 1'b0};
        case (dig)
            2'd0: begin
                dval  = cur.digit_ones;
                shown = 1'b1;
            end
            2'd1: begin
                dval  = cur.digit_tens;
                shown = cur.show_tens;
            end
            default: begin
                dval  = cur.digit_hundreds;
                shown = cur.show_hundreds;
            end
        endcase
        waddr      = {3'b000, base[2:1], sub[0]};
        wnib       = sub[1] ? (sub[0] ? seg_second(dval) : seg_first(dval)) : 4'd0;
        digit_done = (sub == 2'd3) || ((sub == 2'd1) && !shown);

        case (cur.req_type)
            REQ_CMD: begin
                f_word = {2'b00, CMD_ID, cur.command_byte};
                f_len  = CMD_LEN;
                f_last = 1'b1;
                f_next = 4'd0;
            end
            REQ_WRITE: begin
                f_word = {WRITE_ID, cur.ram_address, reverse4(cur.nibble_value)};
                f_len  = WRITE_LEN;
                f_last = 1'b1;
                f_next = 4'd0;
            end
            default: begin
                f_word = {WRITE_ID, waddr, reverse4(wnib)};
                f_len  = WRITE_LEN;
                f_last = digit_done && (dig == 2'd2);
                f_next = digit_done ? {2'(dig + 2'd1), 2'b00} : step + 4'd1;
            end
        endcase
    end

    always_comb begin
        busy_next    = busy_reg;
        ent_next     = ent_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = emit;
        end
        if (emit) begin
            busy_next = !f_last;
            step_next = f_next;
            if (!busy_reg) begin
                ent_next = in_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg  <= ent_next;
        step_reg <= step_next;
        if (emit) begin
            m_word_reg <= f_word;
            m_len_reg  <= f_len;
            m_last_reg <= f_last;
        end
    end

endmodule

`default_nettype wire

@@ tb/segment_lcd_frame_writer_unit_tb.sv @@
`default_nettype none

module segment_lcd_frame_writer_unit_tb;
    import slfw_pkg::*;

    // The last requests and all frames belonging to them run without any idling,
    // so the end of the run also sees the block at full rate.
    localparam int CALM_TAIL      = 40;
    localparam int RANDOM_ITEMS   = 320;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int MAX_REPORTS    = 10;

    // Segment patterns of the ten digits. The lower nibble goes to the even
    // address of a digit pair and the upper nibble goes to the odd one.
    localparam logic [3:0] SEG_EVEN [10] = '{4'hB, 4'h0, 4'h7, 4'h5, 4'hC,
                                             4'hD, 4'hF, 4'h8, 4'hF, 4'hD};
    localparam logic [3:0] SEG_ODD  [10] = '{4'hE, 4'h6, 4'hC, 4'hE, 4'h6,
                                             4'hA, 4'hA, 4'hE, 4'hE, 4'hE};

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  command_byte;
        logic [5:0]  ram_address;
        logic [3:0]  nibble_value;
        logic [15:0] number_value;
    } lcd_request_t;

    typedef struct packed {
        logic [12:0] frame_word;
        logic [3:0]  frame_length;
        logic        last_frame;
    } lcd_frame_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type     = REQ_NONE;
    logic [7:0]  s_command_byte = '0;
    logic [5:0]  s_ram_address  = '0;
    logic [3:0]  s_nibble_value = '0;
    logic [15:0] s_number_value = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [12:0] m_frame_word;
    logic [3:0]  m_frame_length;
    logic        m_last_frame;

    // Requests not yet offered, and frames that the block still owes us.
    lcd_request_t pending_requests[$];
    lcd_frame_t   expected_frames[$];

    lcd_request_t offered_request;
    int           request_count [4];
    int           frames_checked;
    int           mismatch_count;
    int           idle_watch;
    int           src_gap_left;
    int           src_gap_pct;
    int           sink_stall_left;
    int           sink_stall_pct;

    segment_lcd_frame_writer_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_command_byte (s_command_byte),
        .s_ram_address  (s_ram_address),
        .s_nibble_value (s_nibble_value),
        .s_number_value (s_number_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_word   (m_frame_word),
        .m_frame_length (m_frame_length),
        .m_last_frame   (m_last_frame)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // A display memory write frame: ID bits, six address bits MSB first, then
    // the data nibble, which is shifted out LSB first and therefore sits
    // bit-reversed in the word.
    function automatic void expect_write(input logic [5:0] addr, input logic [3:0] nib,
                                         input logic last);
        lcd_frame_t f;
        f.frame_word   = {WRITE_ID, addr, nib[0], nib[1], nib[2], nib[3]};
        f.frame_length = WRITE_LEN;
        f.last_frame   = last;
        expected_frames.push_back(f);
    endfunction

    // Works out every frame that one accepted request must produce, in order.
    function automatic void predict_frames(input lcd_request_t r);
        lcd_frame_t  f;
        int          n;
        int          scale;
        int          digit;
        logic [5:0]  base;
        logic        shown;
        logic        final_pair;
        n = int'(r.number_value);
        case (r.req_type)
            REQ_CMD: begin
                f.frame_word   = {2'b00, CMD_ID, r.command_byte};
                f.frame_length = CMD_LEN;
                f.last_frame   = 1'b1;
                expected_frames.push_back(f);
            end
            REQ_WRITE: begin
                expect_write(r.ram_address, r.nibble_value, 1'b1);
            end
            REQ_NUMBER: begin
                // Ones go to addresses 4 and 5, tens to 2 and 3, hundreds to 0 and 1.
                // A digit is always cleared first; a tens or hundreds digit that is a leading zero
                // stops there, while a shown one gets its two segment nibbles.
                scale = 1;
                for (int d = 0; d < 3; d++) begin
                    digit      = (n / scale) % 10;
                    base       = 6'(4 - 2 * d);
                    shown      = (d == 0) || (n >= scale);
                    final_pair = (d == 2);
                    expect_write(base, 4'h0, 1'b0);
                    expect_write(base + 6'd1, 4'h0, final_pair && !shown);
                    if (shown) begin
                        expect_write(base, SEG_EVEN[digit], 1'b0);
                        expect_write(base + 6'd1, SEG_ODD[digit], final_pair);
                    end
                    scale = scale * 10;
                end
            end
            default: begin
                // The unused request code produces nothing at all.
            end
        endcase
    endfunction

    // Source side. The payload is only changed when the channel is free after
    // this edge: either nothing was offered, or the offered item transfers now.
    // Gaps come in bursts whose density changes from time to time, including
    // stretches with no gaps at all.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid      <= 1'b0;
            src_gap_left = 0;
            src_gap_pct  = 25;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_frames(offered_request);
                request_count[offered_request.req_type]++;
            end
            if ($urandom_range(0, 47) == 0) begin
                src_gap_pct = 20 * $urandom_range(0, 3);
            end
            if (src_gap_left > 0) begin
                src_gap_left--;
                s_valid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_requests.size() > CALM_TAIL &&
                         $urandom_range(0, 99) < src_gap_pct) begin
                src_gap_left = $urandom_range(1, 3) - 1;
                s_valid      <= 1'b0;
            end else begin
                offered_request = pending_requests.pop_front();
                s_valid         <= 1'b1;
                s_req_type      <= offered_request.req_type;
                s_command_byte  <= offered_request.command_byte;
                s_ram_address   <= offered_request.ram_address;
                s_nibble_value  <= offered_request.nibble_value;
                s_number_value  <= offered_request.number_value;
            end
        end
    end

    // Result side. Every frame transfer is checked field by field against the
    // oldest frame still owed. The ready line stalls in bursts like the source.
    always @(posedge aclk) begin
        lcd_frame_t want;
        if (!aresetn) begin
            m_ready         <= 1'b0;
            sink_stall_left = 0;
            sink_stall_pct  = 25;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("ERROR: unexpected frame word=%h length=%0d last=%0d",
                                 m_frame_word, m_frame_length, m_last_frame);
                    end
                end else begin
                    want = expected_frames.pop_front();
                    frames_checked++;
                    if (m_frame_word !== want.frame_word ||
                        m_frame_length !== want.frame_length ||
                        m_last_frame !== want.last_frame) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("ERROR: frame %0d expected word=%h length=%0d last=%0d",
                                     frames_checked, want.frame_word, want.frame_length,
                                     want.last_frame);
                            $display("       actual   word=%h length=%0d last=%0d",
                                     m_frame_word, m_frame_length, m_last_frame);
                        end
                    end
                end
            end
            if ($urandom_range(0, 47) == 0) begin
                sink_stall_pct = 20 * $urandom_range(0, 3);
            end
            if (sink_stall_left > 0) begin
                sink_stall_left--;
                m_ready <= 1'b0;
            end else if (pending_requests.size() > CALM_TAIL &&
                         $urandom_range(0, 99) < sink_stall_pct) begin
                sink_stall_left = $urandom_range(1, 3) - 1;
                m_ready         <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // The run is stuck if neither channel transfers anything for a long time.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_watch <= 0;
        end else if (idle_watch >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d frames still owed",
                     idle_watch, expected_frames.size());
            $display("FAIL segment_lcd_frame_writer_unit");
            $finish;
        end else begin
            idle_watch <= idle_watch + 1;
        end
    end

    // Appends one request; fields that the request type does not use still
    // carry random values, since the block has to ignore them.
    task automatic queue_request(input logic [1:0] kind, input logic [7:0] cmd,
                                 input logic [5:0] addr, input logic [3:0] nib,
                                 input logic [15:0] num);
        lcd_request_t r;
        r.req_type     = kind;
        r.command_byte = (kind == REQ_CMD)    ? cmd  : 8'($urandom_range(0, 255));
        r.ram_address  = (kind == REQ_WRITE)  ? addr : 6'($urandom_range(0, 63));
        r.nibble_value = (kind == REQ_WRITE)  ? nib  : 4'($urandom_range(0, 15));
        r.number_value = (kind == REQ_NUMBER) ? num  : 16'($urandom_range(0, 65535));
        pending_requests.push_back(r);
    endtask

    initial begin
        logic [1:0]  kind;
        logic [15:0] num;
        int          pick;

        // Directed part: command and address extremes, all three blanking
        // patterns at their boundaries, zeros shown inside large values,
        // the top of the number range and the unused request code.
        queue_request(REQ_CMD, 8'h00, '0, '0, '0);
        queue_request(REQ_CMD, 8'hFF, '0, '0, '0);
        queue_request(REQ_CMD, 8'hA5, '0, '0, '0);
        queue_request(REQ_WRITE, '0, 6'd0, 4'h0, '0);
        queue_request(REQ_WRITE, '0, 6'd63, 4'hF, '0);
        queue_request(REQ_WRITE, '0, 6'h2A, 4'h1, '0);
        queue_request(REQ_WRITE, '0, 6'h15, 4'h8, '0);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd0);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd9);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd10);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd99);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd100);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd999);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd1000);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd1005);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd12345);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd65535);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd478);
        queue_request(REQ_NUMBER, '0, '0, '0, 16'd60);
        queue_request(REQ_NONE, '0, '0, '0, '0);
        queue_request(REQ_NONE, '0, '0, '0, '0);

        // Random part. Number values are spread over the three blanking ranges
        // and the full 16-bit range so every digit count is exercised often.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                kind = REQ_CMD;
            end else if (pick < 55) begin
                kind = REQ_WRITE;
            end else if (pick < 95) begin
                kind = REQ_NUMBER;
            end else begin
                kind = REQ_NONE;
            end
            case ($urandom_range(0, 3))
                0:       num = 16'($urandom_range(0, 9));
                1:       num = 16'($urandom_range(10, 99));
                2:       num = 16'($urandom_range(100, 999));
                default: num = 16'($urandom_range(0, 65535));
            endcase
            queue_request(kind, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                          4'($urandom_range(0, 15)), num);
        end

        // Synchronous reset, held low from the start, then released once.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every request has transferred and every owed frame has
        // arrived, then watch a little longer for any stray frames.
        @(posedge aclk);
        while (pending_requests.size() != 0 || s_valid || expected_frames.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d command, %0d nibble, %0d number and %0d unused requests.",
                 request_count[REQ_CMD], request_count[REQ_WRITE],
                 request_count[REQ_NUMBER], request_count[REQ_NONE]);
        $display("Checked %0d frames and found %0d mismatches.",
                 frames_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS segment_lcd_frame_writer_unit");
        end else begin
            $display("FAIL segment_lcd_frame_writer_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/slfw_pkg.sv
rtl/slfw_front.sv
rtl/slfw_queue.sv
rtl/slfw_back.sv
rtl/segment_lcd_frame_writer_unit.sv
tb/segment_lcd_frame_writer_unit_tb.sv
